FILE: src/hrot_pkg.sv
package hrot_pkg;

  localparam int CH_W     = 8;
  localparam int DEG_W    = 9;
  localparam int DEN_W    = 11;
  localparam int REM_W    = DEN_W + 1;
  localparam int LANES    = 2;
  localparam int LANE_SAT = 0;
  localparam int LANE_HUE = 1;

  localparam logic [DEG_W-1:0] DEG_TURN = DEG_W'(360);

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [DEN_W-1:0] den_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

FILE: src/hrot_if.sv
interface hrot_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [hrot_pkg::CH_W-1:0]     red_in;
  logic [hrot_pkg::CH_W-1:0]     green_in;
  logic [hrot_pkg::CH_W-1:0]     blue_in;
  logic [hrot_pkg::DEG_W-1:0]    hue_offset_degrees;

  modport source(output valid, red_in, green_in, blue_in, hue_offset_degrees, input ready);
  modport sink(input valid, red_in, green_in, blue_in, hue_offset_degrees, output ready);
endinterface

interface hrot_result_if;
  logic                      valid;
  logic                      ready;
  logic [hrot_pkg::CH_W-1:0] red_out;
  logic [hrot_pkg::CH_W-1:0] green_out;
  logic [hrot_pkg::CH_W-1:0] blue_out;

  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: src/hrot_div.sv
module hrot_div #(
  parameter int FB = 16,
  parameter int SW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [hrot_pkg::DEN_W-1:0] num [hrot_pkg::LANES],
  input  logic [hrot_pkg::DEN_W-1:0] den [hrot_pkg::LANES],
  input  logic [SW-1:0]              side_in,
  output logic                       out_valid,
  output logic [FB:0]                quo [hrot_pkg::LANES],
  output logic [SW-1:0]              side_out
);

  localparam int STEPS = FB + 1;
  localparam int QW    = FB + 1;
  localparam int RW    = hrot_pkg::REM_W;
  localparam int DW    = hrot_pkg::DEN_W;
  localparam int NL    = hrot_pkg::LANES;

  logic [STEPS-1:0] vld;
  logic [SW-1:0]    side [STEPS];
  logic [RW-1:0]    rem  [STEPS][NL];
  logic [QW-1:0]    q    [STEPS][NL];
  logic [DW-1:0]    dn   [STEPS][NL];

  // One quotient bit per stage: restoring division, MSB first.
  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [RW-1:0] trial  [NL];
    logic [QW-1:0] q_src  [NL];
    logic [DW-1:0] d_src  [NL];
    logic          v_src;
    logic [SW-1:0] sd_src;

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          trial[l] = RW'(num[l]);
          q_src[l] = '0;
          d_src[l] = den[l];
        end
        v_src  = in_valid;
        sd_src = side_in;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          trial[l] = {rem[s-1][l][RW-2:0], 1'b0};
          q_src[l] = q[s-1][l];
          d_src[l] = dn[s-1][l];
        end
        v_src  = vld[s-1];
        sd_src = side[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[s] <= sd_src;
        for (int l = 0; l < NL; l++) begin
          dn[s][l] <= d_src[l];
          if (trial[l] >= {1'b0, d_src[l]}) begin
            rem[s][l] <= trial[l] - {1'b0, d_src[l]};
            q[s][l]   <= {q_src[l][QW-2:0], 1'b1};
          end else begin
            rem[s][l] <= trial[l];
            q[s][l]   <= {q_src[l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign side_out  = side[STEPS-1];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      quo[l] = q[STEPS-1][l];
    end
  end

endmodule

FILE: src/hue_rotate_rgb_pixel_top.sv
// Hue rotation of an 8-bit RGB pixel stream.
// Input channel "pixel" carries red_in, green_in, blue_in and hue_offset_degrees
// (0..359; larger codes wrap once by 360). Output channel "result" carries the
// rotated red_out, green_out, blue_out. Both use valid/ready; a request moves
// at a clock edge where both are high.
// Each pixel goes RGB -> HSV, the hue is turned by the offset, then HSV -> RGB.
// Saturation and hue come from two lanes of one bit-per-stage divider; the
// offset comes from a reciprocal multiply in the first stage.
// The pipeline has one stage for max/min and offset, FRACTION_BITS + 1 divider
// stages, then hue add, sector split, products, channel scaling and the output
// register. Throughput is one pixel per clock while the output is not stalled;
// pixels keep their order.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and pixel.ready drops; nothing is lost or repeated.
// Synchronous reset clears every valid bit; no pass is needed after reset.
module hue_rotate_rgb_pixel_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  hrot_pixel_if.sink           pixel,
  hrot_result_if.source        result
);

  localparam int F   = FRACTION_BITS;
  localparam int QW  = F + 1;
  localparam int CW  = hrot_pkg::CH_W;
  localparam int DW  = hrot_pkg::DEN_W;
  localparam int PW  = 2 * F + 2;
  localparam int XW  = CW + PW;
  localparam int MW  = F + 10;

  localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};
  localparam logic [PW-1:0] ONE2  = {2'b01, {(2 * F){1'b0}}};
  // ceil(2^(F+18) / 360): deg * OFF_MUL >> 18 is exactly deg * 2^F / 360 for deg < 360
  localparam logic [MW-1:0] OFF_MUL = MW'(((64'd1 << (F + 18)) + 64'd359) / 64'd360);

  logic adv;
  logic g_valid;

  assign adv         = !g_valid || result.ready;
  assign pixel.ready = adv;

  // Stage A: max, min, spread, offset reduction and scaling
  hrot_pkg::chan_t mx_c, mn_c;
  logic [hrot_pkg::DEG_W-1:0] deg_c;
  logic [F+18:0] off_prod;

  always_comb begin
    mx_c = pixel.red_in;
    mn_c = pixel.red_in;
    if (pixel.green_in > mx_c) mx_c = pixel.green_in;
    if (pixel.blue_in  > mx_c) mx_c = pixel.blue_in;
    if (pixel.green_in < mn_c) mn_c = pixel.green_in;
    if (pixel.blue_in  < mn_c) mn_c = pixel.blue_in;
    deg_c = (pixel.hue_offset_degrees >= hrot_pkg::DEG_TURN)
          ? pixel.hue_offset_degrees - hrot_pkg::DEG_TURN
          : pixel.hue_offset_degrees;
    off_prod = (F + 19)'(deg_c) * (F + 19)'(OFF_MUL);
  end

  logic                       a_valid;
  hrot_pkg::chan_t            a_r, a_g, a_b, a_mx, a_d;
  logic [F-1:0]               a_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= pixel.red_in;
      a_g   <= pixel.green_in;
      a_b   <= pixel.blue_in;
      a_mx  <= mx_c;
      a_d   <= mx_c - mn_c;
      a_off <= off_prod[F+17:18];
    end
  end

  // Sector numerator and divider operands
  hrot_pkg::den_t d_w, r_w, g_w, b_w, six_d, n_c;
  hrot_pkg::den_t div_num [hrot_pkg::LANES];
  hrot_pkg::den_t div_den [hrot_pkg::LANES];

  always_comb begin
    d_w   = DW'(a_d);
    r_w   = DW'(a_r);
    g_w   = DW'(a_g);
    b_w   = DW'(a_b);
    six_d = (d_w << 2) + (d_w << 1);
    if (a_mx == a_r) begin
      n_c = (a_g < a_b) ? six_d + g_w - b_w : g_w - b_w;
    end else if (a_mx == a_g) begin
      n_c = (d_w << 1) + b_w - r_w;
    end else begin
      n_c = (d_w << 2) + r_w - g_w;
    end
    div_num[hrot_pkg::LANE_SAT] = d_w;
    div_den[hrot_pkg::LANE_SAT] = (a_mx == '0) ? DW'(1) : DW'(a_mx);
    // gray pixel: hue stays zero
    div_num[hrot_pkg::LANE_HUE] = (a_d == '0) ? '0 : n_c;
    div_den[hrot_pkg::LANE_HUE] = (a_d == '0) ? DW'(1) : six_d;
  end

  logic            q_valid;
  logic [QW-1:0]   quo [hrot_pkg::LANES];
  logic [CW+F-1:0] q_side;
  hrot_pkg::chan_t q_v;
  logic [F-1:0]    q_off;

  hrot_div #(.FB(F), .SW(CW + F)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (a_valid),
    .num      (div_num),
    .den      (div_den),
    .side_in  ({a_off, a_mx}),
    .out_valid(q_valid),
    .quo      (quo),
    .side_out (q_side)
  );

  assign q_v   = q_side[CW-1:0];
  assign q_off = q_side[CW+F-1:CW];

  // Stage C: rotate hue; the sum stays below two turns, so dropping bit F wraps it
  logic [QW-1:0]   hsum;
  logic            c_valid;
  logic [F-1:0]    c_h2;
  logic [QW-1:0]   c_sat;
  hrot_pkg::chan_t c_v;

  assign hsum = quo[hrot_pkg::LANE_HUE] + QW'(q_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_h2  <= hsum[F-1:0];
      c_sat <= quo[hrot_pkg::LANE_SAT];
      c_v   <= q_v;
    end
  end

  // Stage D: sector and fraction
  logic [F+2:0]      h6;
  logic              d_valid;
  hrot_pkg::sector_t d_sector;
  logic [F-1:0]      d_f;
  logic [QW-1:0]     d_omf, d_oms, d_sat;
  hrot_pkg::chan_t   d_v;

  assign h6 = ((F + 3)'(c_h2) << 2) + ((F + 3)'(c_h2) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sector <= hrot_pkg::sector_t'(h6[F+2:F]);
      d_f      <= h6[F-1:0];
      d_omf    <= ONE_Q - QW'(h6[F-1:0]);
      d_oms    <= ONE_Q - c_sat;
      d_sat    <= c_sat;
      d_v      <= c_v;
    end
  end

  // Stage E: products with saturation
  logic              e_valid;
  hrot_pkg::sector_t e_sector;
  logic [PW-1:0]     e_fs, e_ofs;
  logic [CW+QW-1:0]  e_pm;
  hrot_pkg::chan_t   e_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_sector <= d_sector;
      e_fs     <= PW'(d_f) * PW'(d_sat);
      e_ofs    <= PW'(d_omf) * PW'(d_sat);
      e_pm     <= (CW + QW)'(d_v) * (CW + QW)'(d_oms);
      e_v      <= d_v;
    end
  end

  // Stage F: scale by value, truncate
  logic [XW-1:0]     q_prod, t_prod;
  logic              f_valid;
  hrot_pkg::sector_t f_sector;
  hrot_pkg::chan_t   f_p, f_q, f_t, f_v;

  assign q_prod = XW'(e_v) * XW'(ONE2 - e_fs);
  assign t_prod = XW'(e_v) * XW'(ONE2 - e_ofs);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_sector <= e_sector;
      f_p      <= e_pm[F+CW-1:F];
      f_q      <= q_prod[2*F+CW-1:2*F];
      f_t      <= t_prod[2*F+CW-1:2*F];
      f_v      <= e_v;
    end
  end

  // Stage G: channel select into the output register
  hrot_pkg::chan_t ro_c, go_c, bo_c;
  hrot_pkg::chan_t g_r, g_g, g_b;

  always_comb begin
    unique case (f_sector)
      hrot_pkg::SEC_RED_YEL: begin ro_c = f_v; go_c = f_t; bo_c = f_p; end
      hrot_pkg::SEC_YEL_GRN: begin ro_c = f_q; go_c = f_v; bo_c = f_p; end
      hrot_pkg::SEC_GRN_CYN: begin ro_c = f_p; go_c = f_v; bo_c = f_t; end
      hrot_pkg::SEC_CYN_BLU: begin ro_c = f_p; go_c = f_q; bo_c = f_v; end
      hrot_pkg::SEC_BLU_MAG: begin ro_c = f_t; go_c = f_p; bo_c = f_v; end
      default:               begin ro_c = f_v; go_c = f_p; bo_c = f_q; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r <= ro_c;
      g_g <= go_c;
      g_b <= bo_c;
    end
  end

  assign result.valid     = g_valid;
  assign result.red_out   = g_r;
  assign result.green_out = g_g;
  assign result.blue_out  = g_b;

  a_hue_below_turn: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (quo[hrot_pkg::LANE_HUE] < ONE_Q))
    else $error("hue quotient reached a full turn");

  a_sat_in_range: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> c_sat <= ONE_Q)
    else $error("saturation above one");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !pixel.ready)
    else $error("input taken while output stalled");

endmodule
